### rtl/core/attribute_screen_pixel_generator_core_defines.svh
// Assertion macros shared by the attribute screen pixel generator RTL.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ATTRIBUTE_SCREEN_PIXEL_GENERATOR_CORE_DEFINES_SVH
`define ATTRIBUTE_SCREEN_PIXEL_GENERATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define ASPG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASPG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/aspg_pkg.sv
`timescale 1ns / 1ps

package aspg_pkg;

    localparam int ADDR_W = 13;

    // Command codes.
    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_RENDER = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Video store layout.
    localparam int STORE_DEPTH = 6912;
    localparam logic [ADDR_W-1:0] STORE_LIMIT = 13'd6912;
    localparam logic [ADDR_W-1:0] PIXEL_LIMIT = 13'd6144;
    localparam logic [ADDR_W-1:0] ATTR_BASE   = 13'h1800;

    // Flash phase counts 0..33; colors swap above 16.
    localparam logic [5:0] FLASH_WRAP_ABOVE = 6'd32;
    localparam logic [5:0] FLASH_SWAP_ABOVE = 6'd16;

    // Everything the serializer needs to emit one pixel byte.
    typedef struct packed {
        logic [7:0] pix;
        logic [2:0] ink;
        logic [2:0] paper;
        logic       bright;
        logic [4:0] col;
        logic [7:0] y;
    } ser_load_t;

endpackage

### rtl/core/attribute_screen_pixel_generator_core.sv
`timescale 1ns / 1ps
`include "attribute_screen_pixel_generator_core_defines.svh"

// Attribute-mode screen pixel generator. A transaction is accepted when start
// is high and busy is low. After a write or a frame tick busy stays low. A
// render of a pixel-byte offset below 6144 raises busy until its last pixel
// has left: the pixel byte is read from the video store in the accept cycle,
// the attribute byte in the next cycle, the attribute is decoded in the load
// state, and eight pixels then leave one per cycle, most significant bit
// first. The store's one read port serves the two reads in turn. Each pixel
// is on the result ports for exactly one cycle while strobe is high; the
// receiver cannot stall the block, so it must take every pixel in the cycle
// it appears. last_pixel marks the eighth pixel of a byte. Writes at
// addresses of 6912 or more, renders of offsets of 6144 or more, and the
// unused command code are accepted and have no effect. The video store has
// no reset; a render must only touch bytes written before.

module attribute_screen_pixel_generator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [12:0] address,
    input  logic [7:0]  data,
    output logic        strobe,
    output logic [7:0]  pixel_x,
    output logic [7:0]  pixel_y,
    output logic [2:0]  colour_index,
    output logic        bright_shown,
    output logic        last_pixel
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ATTR,
        S_LOAD
    } state_t;

    state_t              state_reg;
    logic [5:0]          flash_phase_reg;
    logic [7:0]          pix_reg;
    logic [7:0]          y_reg;
    logic [4:0]          col_reg;

    logic                accept;
    logic                store_we;
    logic                render_ok;
    logic [12:0]         store_raddr;
    logic [12:0]         attr_addr;
    logic [7:0]          store_rdata;
    logic                ser_active;
    logic                ser_load;
    logic                swap;
    aspg_pkg::ser_load_t ser_data;

    assign accept    = start && !busy;
    assign store_we  = accept && (command == aspg_pkg::CMD_WRITE) &&
                       (address < aspg_pkg::STORE_LIMIT);
    assign render_ok = accept && (command == aspg_pkg::CMD_RENDER) &&
                       (address < aspg_pkg::PIXEL_LIMIT);

    // The attribute cell index is the character row (y / 8) followed by the
    // column, which falls straight out of the decoded row bits.
    assign attr_addr   = aspg_pkg::ATTR_BASE + {3'b000, y_reg[7:3], col_reg};

    // In idle the store reads the incoming offset, so the pixel byte is
    // ready in the cycle after a render is accepted.
    assign store_raddr = (state_reg == S_IDLE) ? address : attr_addr;

    aspg_store u_store
    (
        .clk   (clk),
        .we    (store_we),
        .waddr (address),
        .wdata (data),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            flash_phase_reg <= 6'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (render_ok)
                    begin
                        state_reg <= S_ATTR;
                    end
                    if (accept && (command == aspg_pkg::CMD_TICK))
                    begin
                        if (flash_phase_reg > aspg_pkg::FLASH_WRAP_ABOVE)
                        begin
                            flash_phase_reg <= 6'd0;
                        end
                        else
                        begin
                            flash_phase_reg <= flash_phase_reg + 6'd1;
                        end
                    end
                end
                S_ATTR:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload captured along the render: the decoded row and column at
    // acceptance, and the pixel byte when it comes out of the store.
    always_ff @(posedge clk)
    begin
        if (render_ok)
        begin
            y_reg   <= {address[12:11], address[7:5], address[10:8]};
            col_reg <= address[4:0];
        end
        if (state_reg == S_ATTR)
        begin
            pix_reg <= store_rdata;
        end
    end

    // In the load cycle the store output holds the attribute byte.
    assign ser_load = (state_reg == S_LOAD);
    assign swap     = store_rdata[7] && (flash_phase_reg > aspg_pkg::FLASH_SWAP_ABOVE);

    always_comb
    begin
        ser_data.pix    = pix_reg;
        ser_data.ink    = swap ? store_rdata[5:3] : store_rdata[2:0];
        ser_data.paper  = swap ? store_rdata[2:0] : store_rdata[5:3];
        ser_data.bright = store_rdata[6];
        ser_data.col    = col_reg;
        ser_data.y      = y_reg;
    end

    aspg_serial u_serial
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (ser_load),
        .load_data    (ser_data),
        .active       (ser_active),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .colour_index (colour_index),
        .bright_shown (bright_shown),
        .last_pixel   (last_pixel)
    );

    assign busy   = (state_reg != S_IDLE) || ser_active;
    assign strobe = ser_active;

    // A valid render must raise busy in the following cycle.
    `ASPG_ASSERT_NXT(a_render_busy, clk, rst_n, render_ok, busy)
    // The serializer starts emitting right after the attribute is decoded.
    `ASPG_ASSERT_NXT(a_load_strobe, clk, rst_n, ser_load, strobe)
    // The flash phase never leaves its 34-frame range.
    `ASPG_ASSERT_IMP(a_flash_range, clk, rst_n, 1'b1, flash_phase_reg <= 6'd33)
    // The fetch sequencer and the serializer never run at once.
    `ASPG_ASSERT_IMP(a_no_overlap, clk, rst_n, ser_active, state_reg == S_IDLE)
    // A last pixel ends the byte: no strobe follows in the next cycle.
    `ASPG_ASSERT_NXT(a_last_ends, clk, rst_n, strobe && last_pixel, !strobe)

endmodule

### rtl/core/aspg_store.sv
`timescale 1ns / 1ps

module aspg_store
(
    input  logic                            clk,
    input  logic                            we,
    input  logic [aspg_pkg::ADDR_W-1:0]     waddr,
    input  logic [7:0]                      wdata,
    input  logic [aspg_pkg::ADDR_W-1:0]     raddr,
    output logic [7:0]                      rdata
);

    logic [7:0] mem [0:aspg_pkg::STORE_DEPTH-1];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/aspg_serial.sv
`timescale 1ns / 1ps

module aspg_serial
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  aspg_pkg::ser_load_t   load_data,
    output logic                  active,
    output logic [7:0]            pixel_x,
    output logic [7:0]            pixel_y,
    output logic [2:0]            colour_index,
    output logic                  bright_shown,
    output logic                  last_pixel
);

    logic                active_reg;
    logic                active_next;
    logic [2:0]          cnt_reg;
    logic [2:0]          cnt_next;
    aspg_pkg::ser_load_t info_reg;
    aspg_pkg::ser_load_t info_next;
    logic [2:0]          colour;

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        info_next   = info_reg;
        if (load)
        begin
            active_next = 1'b1;
            cnt_next    = 3'd0;
            info_next   = load_data;
        end
        else if (active_reg)
        begin
            cnt_next      = cnt_reg + 3'd1;
            info_next.pix = {info_reg.pix[6:0], 1'b0};
            if (cnt_reg == 3'd7)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

    // The pixel bit leaving the top of the shift register picks ink or paper.
    assign colour       = info_reg.pix[7] ? info_reg.ink : info_reg.paper;
    assign active       = active_reg;
    assign pixel_x      = {info_reg.col, cnt_reg};
    assign pixel_y      = info_reg.y;
    assign colour_index = colour;
    assign bright_shown = info_reg.bright && (colour != 3'd0);
    assign last_pixel   = (cnt_reg == 3'd7);

endmodule
